// ===== rtl/sha512_hash_engine_defines.svh =====
// assertion macros shared by the sha512 hash engine checkers
// needs nothing else; taken in by `include where assertions are written
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define SHA512_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define SHA512_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha512_pkg.sv =====
// shared types, constants and functions of the sha512 hash engine
// no dependencies; used by sha512_round, sha512_hash_engine and sha512_checker
package sha512_pkg;

    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;

    localparam logic [63:0] PAD_TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef logic [HASH_WORDS-1:0][63:0]  hash_vec_t;
    typedef logic [BLOCK_WORDS-1:0][63:0] sched_vec_t;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  digest_index;
        logic        final_word;
    } digest_item_t;

    // rotate right by n bit positions
    function automatic logic [63:0] rotr64(input logic [63:0] x, input logic [5:0] n);
        logic [127:0] both;
        both = {x, x} >> n;
        return both[63:0];
    endfunction

    function automatic hash_vec_t initial_hash();
        hash_vec_t iv;
        iv[0] = 64'h6a09e667f3bcc908;
        iv[1] = 64'hbb67ae8584caa73b;
        iv[2] = 64'h3c6ef372fe94f82b;
        iv[3] = 64'ha54ff53a5f1d36f1;
        iv[4] = 64'h510e527fade682d1;
        iv[5] = 64'h9b05688c2b3e6c1f;
        iv[6] = 64'h1f83d9abfb41bd6b;
        iv[7] = 64'h5be0cd19137e2179;
        return iv;
    endfunction

    // round constants; indexes past the last round read as zero
    function automatic logic [63:0] round_k(input logic [6:0] idx);
        logic [63:0] k;
        unique case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/sha512_round.sv =====
// shared sha512 round unit: one compression round and the next schedule word
// depends on sha512_pkg
module sha512_round (
    input  sha512_pkg::hash_vec_t  work,
    input  logic [63:0]            kw,
    input  sha512_pkg::sched_vec_t window,
    output sha512_pkg::hash_vec_t  work_next,
    output logic [63:0]            sched_word
);

    logic [63:0] big_s0;
    logic [63:0] big_s1;
    logic [63:0] ch;
    logic [63:0] maj;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] small_s0;
    logic [63:0] small_s1;

    // round function, working word 0 is a
    always_comb
    begin
        big_s1 = sha512_pkg::rotr64(work[4], 6'd14) ^ sha512_pkg::rotr64(work[4], 6'd18)
               ^ sha512_pkg::rotr64(work[4], 6'd41);
        ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
        t1     = work[7] + big_s1 + ch + kw;
        big_s0 = sha512_pkg::rotr64(work[0], 6'd28) ^ sha512_pkg::rotr64(work[0], 6'd34)
               ^ sha512_pkg::rotr64(work[0], 6'd39);
        maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
        t2     = big_s0 + maj;

        work_next[7] = work[6];
        work_next[6] = work[5];
        work_next[5] = work[4];
        work_next[4] = work[3] + t1;
        work_next[3] = work[2];
        work_next[2] = work[1];
        work_next[1] = work[0];
        work_next[0] = t1 + t2;
    end

    // message expansion, window entry 0 is the word used this round
    always_comb
    begin
        small_s0 = sha512_pkg::rotr64(window[1], 6'd1) ^ sha512_pkg::rotr64(window[1], 6'd8)
                 ^ (window[1] >> 7);
        small_s1 = sha512_pkg::rotr64(window[14], 6'd19)
                 ^ sha512_pkg::rotr64(window[14], 6'd61) ^ (window[14] >> 6);
        sched_word = window[0] + small_s0 + window[9] + small_s1;
    end

endmodule

// ===== rtl/sha512_hash_engine.sv =====
// sha512 hash engine top level: block gathering, padding, round sequencer, digest output
// depends on sha512_pkg and sha512_round
//
//  channel  | dir | payload                                      | handshake
//  msg      | in  | message_word, valid_bytes, last_word         | msg_valid / msg_stall
//  digest   | out | digest_word, digest_index, final_word        | digest_valid / digest_stall
//
// a message word is taken while msg_stall is low; the sixteenth word of a block starts
// a compression (load, 80 rounds through the one round unit, hash update)
// the last word brings padding of the remaining block words, one or two compressions,
// then eight digest words at one per cycle while digest_stall is low
// msg_stall is high whenever the engine is not gathering words
// reset loads the initial hash values and empties the open block
module sha512_hash_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    output logic                      msg_stall,
    input  sha512_pkg::msg_item_t     msg_data,
    output logic                      digest_valid,
    input  logic                      digest_stall,
    output sha512_pkg::digest_item_t  digest_data
);

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    localparam logic [6:0] LAST_ROUND = 7'(sha512_pkg::ROUNDS - 1);
    localparam logic [3:0] LAST_SLOT  = 4'(sha512_pkg::BLOCK_WORDS - 1);
    localparam logic [3:0] LEN_SLOT   = 4'(sha512_pkg::BLOCK_WORDS - 2);
    localparam logic [2:0] LAST_INDEX = 3'(sha512_pkg::HASH_WORDS - 1);

    state_t                  state_reg;
    state_t                  state_next;
    sha512_pkg::hash_vec_t   hash_reg;
    logic [63:0]             bits_reg;
    logic [3:0]              count_reg;
    logic [6:0]              round_reg;
    logic [2:0]              out_idx_reg;
    logic                    pad_active_reg;
    logic                    pad80_reg;
    logic                    len_phase_reg;
    logic                    final_reg;
    logic                    digest_valid_reg;

    sha512_pkg::sched_vec_t  window_reg;
    sha512_pkg::hash_vec_t   work_reg;
    logic [63:0]             kw_reg;
    sha512_pkg::digest_item_t digest_data_reg;

    sha512_pkg::hash_vec_t   work_next;
    logic [63:0]             sched_word;

    logic                    msg_xfer;
    logic                    push_en;
    logic [63:0]             push_word;
    logic                    block_full;
    logic                    out_load;
    logic [3:0]              nbytes;
    logic [5:0]              byte_shift;
    logic [63:0]             tail_word;

    sha512_round u_round (
        .work       (work_reg),
        .kw         (kw_reg),
        .window     (window_reg),
        .work_next  (work_next),
        .sched_word (sched_word)
    );

    assign msg_stall    = (state_reg != ST_COLLECT);
    assign msg_xfer     = msg_valid && !msg_stall;
    assign digest_valid = digest_valid_reg;
    assign digest_data  = digest_data_reg;

    // last word: keep the valid bytes and place the 0x80 marker after them
    always_comb
    begin
        nbytes     = (msg_data.valid_bytes > 4'd8) ? 4'd8 : msg_data.valid_bytes;
        byte_shift = {nbytes[2:0], 3'b000};
        tail_word  = (msg_data.message_word & ~(sha512_pkg::ALL_ONES >> byte_shift))
                   | (sha512_pkg::PAD_TOP_BIT >> byte_shift);
    end

    // word entering the open block
    always_comb
    begin
        push_en   = 1'b0;
        push_word = msg_data.message_word;
        if (msg_xfer)
        begin
            push_en = 1'b1;
            if (msg_data.last_word && (nbytes != 4'd8))
            begin
                push_word = tail_word;
            end
        end
        else if (state_reg == ST_PAD)
        begin
            push_en = 1'b1;
            priority if (pad80_reg)
            begin
                push_word = sha512_pkg::PAD_TOP_BIT;
            end
            else if (len_phase_reg)
            begin
                push_word = bits_reg;
            end
            else
            begin
                push_word = 64'h0;
            end
        end
    end

    assign block_full = push_en && (count_reg == LAST_SLOT);
    assign out_load   = (state_reg == ST_OUTPUT) && (!digest_valid_reg || !digest_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (msg_xfer)
                begin
                    priority if (block_full)
                    begin
                        state_next = ST_INIT;
                    end
                    else if (msg_data.last_word)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                priority if (final_reg)
                begin
                    state_next = ST_OUTPUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_COLLECT;
                end
            end
            ST_OUTPUT:
            begin
                if (out_load && (out_idx_reg == LAST_INDEX))
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // sequencer state, kept hash, length and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_COLLECT;
            hash_reg         <= sha512_pkg::initial_hash();
            bits_reg         <= 64'h0;
            count_reg        <= 4'd0;
            round_reg        <= 7'd0;
            out_idx_reg      <= 3'd0;
            pad_active_reg   <= 1'b0;
            pad80_reg        <= 1'b0;
            len_phase_reg    <= 1'b0;
            final_reg        <= 1'b0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (push_en)
            begin
                count_reg <= block_full ? 4'd0 : count_reg + 4'd1;
            end

            // message length and padding flags
            if (msg_xfer)
            begin
                if (msg_data.last_word)
                begin
                    bits_reg       <= bits_reg + {57'h0, nbytes, 3'b000};
                    pad_active_reg <= 1'b1;
                    pad80_reg      <= (nbytes == 4'd8);
                end
                else
                begin
                    bits_reg <= bits_reg + 64'd64;
                end
            end
            else if (state_reg == ST_PAD)
            begin
                pad80_reg     <= 1'b0;
                len_phase_reg <= (count_reg == LEN_SLOT) && !pad80_reg;
                if (len_phase_reg)
                begin
                    final_reg <= 1'b1;
                end
            end

            // round counter
            if (state_reg == ST_INIT)
            begin
                round_reg <= 7'd0;
            end
            else if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 7'd1;
            end

            // fold working variables into the hash
            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < sha512_pkg::HASH_WORDS; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end

            // digest output register
            if (out_load)
            begin
                digest_valid_reg <= 1'b1;
                out_idx_reg      <= out_idx_reg + 3'd1;
                if (out_idx_reg == LAST_INDEX)
                begin
                    hash_reg       <= sha512_pkg::initial_hash();
                    bits_reg       <= 64'h0;
                    pad_active_reg <= 1'b0;
                    final_reg      <= 1'b0;
                end
            end
            else if (!digest_stall)
            begin
                digest_valid_reg <= 1'b0;
            end
        end
    end

    // schedule window, working variables, round constant plus word, digest payload
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            window_reg <= {push_word, window_reg[sha512_pkg::BLOCK_WORDS-1:1]};
        end
        else if (state_reg == ST_ROUND)
        begin
            window_reg <= {sched_word, window_reg[sha512_pkg::BLOCK_WORDS-1:1]};
        end

        if (state_reg == ST_INIT)
        begin
            work_reg <= hash_reg;
            kw_reg   <= sha512_pkg::round_k(7'd0) + window_reg[0];
        end
        else if (state_reg == ST_ROUND)
        begin
            work_reg <= work_next;
            kw_reg   <= sha512_pkg::round_k(round_reg + 7'd1) + window_reg[1];
        end

        if (out_load)
        begin
            digest_data_reg.digest_word  <= hash_reg[out_idx_reg];
            digest_data_reg.digest_index <= out_idx_reg;
            digest_data_reg.final_word   <= (out_idx_reg == LAST_INDEX);
        end
    end

endmodule

// ===== rtl/sha512_checker.sv =====
// port-level checks for the sha512 hash engine, bound to the top level
// depends on sha512_pkg and sha512_hash_engine_defines.svh
`include "sha512_hash_engine_defines.svh"

module sha512_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    input  logic                      msg_stall,
    input  sha512_pkg::msg_item_t     msg_data,
    input  logic                      digest_valid,
    input  logic                      digest_stall,
    input  sha512_pkg::digest_item_t  digest_data
);

    logic msg_xfer;
    logic digest_xfer;

    assign msg_xfer    = msg_valid && !msg_stall;
    assign digest_xfer = digest_valid && !digest_stall;

    // a stalled digest word holds
    `SHA512_ASSERT_NEXT(a_digest_hold, clk, rst_n, digest_valid && digest_stall, digest_valid && $stable(digest_data), "stalled digest word changed")

    // the final flag marks exactly the last digest position
    `SHA512_ASSERT_NOW(a_final_index, clk, rst_n, digest_valid, digest_data.final_word == (digest_data.digest_index == 3'd7), "final flag and digest index disagree")

    // digest words follow each other without a gap once taken
    `SHA512_ASSERT_NEXT(a_digest_burst, clk, rst_n, digest_xfer && !digest_data.final_word, digest_valid && (digest_data.digest_index == $past(digest_data.digest_index) + 3'd1), "digest words not back to back")

    // the end of a message always leaves the collect state, so input is held off
    `SHA512_ASSERT_NEXT(a_pad_busy, clk, rst_n, msg_xfer && msg_data.last_word, msg_stall, "input taken right after the last word")

endmodule

bind sha512_hash_engine sha512_checker u_sha512_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg_data     (msg_data),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_data  (digest_data)
);
